// ===== design/dvr_pkg.sv =====
// Shared widths, codes and state encoding for the distance-vector relax block.
`timescale 1ns / 1ps

package dvr_pkg;

  // Field widths
  localparam int unsigned NODE_W = 8;
  localparam int unsigned DIST_W = 16;

  // Default route table depth
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Item operation codes
  typedef enum logic {
    OP_ADD_LINK = 1'b0,
    OP_RELAX    = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SKIP    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_e;

endpackage

// ===== design/dvr_in_if.sv =====
// Input channel: one table update item with valid/ready.
`timescale 1ns / 1ps

interface dvr_in_if
  import dvr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [NODE_W-1:0] neighbor_id;
  logic [NODE_W-1:0] dest_node;
  logic [DIST_W-1:0] dest_distance;
  logic              last_entry;

  modport source (
    output valid, opcode, neighbor_id, dest_node, dest_distance, last_entry,
    input  ready
  );

  modport sink (
    input  valid, opcode, neighbor_id, dest_node, dest_distance, last_entry,
    output ready
  );
endinterface

// ===== design/dvr_out_if.sv =====
// Output channel: one update result with valid/ready.
`timescale 1ns / 1ps

interface dvr_out_if
  import dvr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              entry_changed;
  logic              vector_updated;
  logic [1:0]        status;
  logic [DIST_W-1:0] table_distance;

  modport source (
    output valid, entry_changed, vector_updated, status, table_distance,
    input  ready
  );

  modport sink (
    input  valid, entry_changed, vector_updated, status, table_distance,
    output ready
  );
endinterface

// ===== design/dvr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dvr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/distance_vector_relax_top.sv =====
// Distance-vector routing table update: scan, relax and write back one item at a time.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------------------
//   in_i     | in  | valid/ready        | opcode, neighbor_id, dest_node, dest_distance,
//            |     |                    | last_entry
//   out_o    | out | valid/ready        | entry_changed, vector_updated, status,
//            |     |                    | table_distance
//   cfg      | in  | cfg_we_i (no wait) | cfg_wdata_i = self_id
//
// After an item's transfer, the sequencer goes from S_IDLE through S_SCAN and S_LAST to
// S_DECIDE (straight to S_DECIDE with an empty table), and the result is registered on
// commit. The route RAM has a single read port and is scanned one entry per cycle for
// both the destination and the neighbor. No clearing pass after reset: only entries
// below route_count are ever read. A new item is taken once the previous one has been
// written back. A result waits in the output register while the next item is scanned,
// and the write-back stalls only if that register is still occupied.
`timescale 1ns / 1ps

module distance_vector_relax_top
  import dvr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  dvr_in_if.sink            in_i,
  dvr_out_if.source         out_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = NODE_W + DIST_W;

  // Sequencer and counters
  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     scan_idx_q, scan_idx_d;
  logic              flag_q, flag_d;
  logic [NODE_W-1:0] self_id_q;

  // Latched item
  logic              op_q;
  logic [NODE_W-1:0] nb_q;
  logic [NODE_W-1:0] dest_q;
  logic [DIST_W-1:0] dist_q;
  logic              last_q;

  // Scan results
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic              dest_hit_q, dest_hit_d;
  logic [DIST_W-1:0] dest_dist_q, dest_dist_d;
  logic [IW-1:0]     dest_pos_q, dest_pos_d;
  logic              nb_hit_q, nb_hit_d;
  logic [DIST_W-1:0] nb_dist_q, nb_dist_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [NODE_W-1:0] rd_node;
  logic [DIST_W-1:0] rd_dist;

  // Output register
  logic              out_valid_q;
  logic              out_changed_q, out_vupd_q;
  status_e           out_status_q;
  logic [DIST_W-1:0] out_tdist_q;

  // Decision datapath
  logic              accept, commit, full, skip;
  logic [DIST_W:0]   sum_full;
  logic [DIST_W-1:0] sum_sat, known_dist;
  logic              dec_changed, dec_vupd;
  status_e           dec_status;
  logic [DIST_W-1:0] dec_tdist;

  dvr_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_node = ram_rdata[EW-1:DIST_W];
  assign rd_dist = ram_rdata[DIST_W-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == S_DECIDE) && (!out_valid_q || out_o.ready);

  // Capture the first match for destination and neighbor as read data returns
  always_comb begin
    dest_hit_d  = dest_hit_q;
    dest_dist_d = dest_dist_q;
    dest_pos_d  = dest_pos_q;
    nb_hit_d    = nb_hit_q;
    nb_dist_d   = nb_dist_q;
    if (accept) begin
      dest_hit_d = 1'b0;
      nb_hit_d   = 1'b0;
    end else if (rd_vld_q) begin
      if (!dest_hit_q && rd_node == dest_q) begin
        dest_hit_d  = 1'b1;
        dest_dist_d = rd_dist;
        dest_pos_d  = rd_idx_q;
      end
      if (!nb_hit_q && rd_node == nb_q) begin
        nb_hit_d  = 1'b1;
        nb_dist_d = rd_dist;
      end
    end
  end

  // Relax the entry and pick the write-back
  always_comb begin
    full       = (count_q == CW'(TABLE_DEPTH));
    skip       = (dest_q == self_id_q) || (dist_q == '0);
    sum_full   = {1'b0, dist_q} + {1'b0, nb_dist_q};
    sum_sat    = sum_full[DIST_W] ? {DIST_W{1'b1}} : sum_full[DIST_W-1:0];
    known_dist = dest_hit_q ? dest_dist_q : '0;

    dec_changed = 1'b0;
    dec_vupd    = 1'b0;
    dec_status  = ST_OK;
    dec_tdist   = known_dist;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IW-1:0];
    ram_wdata   = {dest_q, dist_q};
    count_d     = count_q;
    flag_d      = flag_q;

    if (op_q == OP_ADD_LINK) begin
      if (!full) begin
        ram_we      = commit;
        dec_changed = 1'b1;
        dec_tdist   = dist_q;
        count_d     = commit ? count_q + CW'(1) : count_q;
      end else begin
        dec_status = ST_FULL;
      end
    end else begin
      if (skip) begin
        dec_status = ST_SKIP;
      end else if (!nb_hit_q) begin
        dec_status = ST_UNKNOWN;
      end else if (!dest_hit_q) begin
        if (!full) begin
          ram_we      = commit;
          ram_wdata   = {dest_q, sum_sat};
          dec_changed = 1'b1;
          dec_tdist   = sum_sat;
          count_d     = commit ? count_q + CW'(1) : count_q;
        end else begin
          dec_status = ST_FULL;
          dec_tdist  = '0;
        end
      end else if (sum_sat < dest_dist_q) begin
        ram_we      = commit;
        ram_waddr   = dest_pos_q;
        ram_wdata   = {dest_q, sum_sat};
        dec_changed = 1'b1;
        dec_tdist   = sum_sat;
      end
      // Track changes over the vector; report and clear on its last entry
      if (commit) begin
        flag_d = flag_q || dec_changed;
        if (last_q) begin
          flag_d = 1'b0;
        end
      end
      dec_vupd = last_q && (flag_q || dec_changed);
    end
  end

  // Next state and scan address
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    ram_re     = 1'b0;
    case (state_q)
      S_IDLE: begin
        scan_idx_d = '0;
        if (accept) begin
          state_d = (count_q == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re     = 1'b1;
        scan_idx_d = scan_idx_q + IW'(1);
        if (CW'(scan_idx_q) + CW'(1) == count_q) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      flag_q      <= 1'b0;
      self_id_q   <= '0;
      rd_vld_q    <= 1'b0;
      dest_hit_q  <= 1'b0;
      nb_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      flag_q     <= flag_d;
      rd_vld_q   <= ram_re;
      dest_hit_q <= dest_hit_d;
      nb_hit_q   <= nb_hit_d;
      if (cfg_we_i) begin
        self_id_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      nb_q   <= in_i.neighbor_id;
      dest_q <= in_i.dest_node;
      dist_q <= in_i.dest_distance;
      last_q <= in_i.last_entry;
    end
    rd_idx_q    <= scan_idx_q;
    dest_dist_q <= dest_dist_d;
    dest_pos_q  <= dest_pos_d;
    nb_dist_q   <= nb_dist_d;
    if (commit) begin
      out_changed_q <= dec_changed;
      out_vupd_q    <= dec_vupd;
      out_status_q  <= dec_status;
      out_tdist_q   <= dec_tdist;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.entry_changed  = out_changed_q;
  assign out_o.vector_updated = out_vupd_q;
  assign out_o.status         = out_status_q;
  assign out_o.table_distance = out_tdist_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("route count exceeds table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + CW'(1))
    else $error("route count moved by other than one");

  a_write_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_DECIDE) && commit)
    else $error("table write outside commit");

  a_changed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && dec_changed |-> dec_status == ST_OK)
    else $error("change reported with non-ok status");

endmodule
